// ===== rtl/dpod_pkg.sv =====
// Shared types, constants and helper functions for the date period overlap block.
package dpod_pkg;

  // Field widths
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned SHARED_W = 22;

  // Linear day number: 365 * 16383 plus leap days and day of year fits in 23 bits
  localparam int unsigned DNUM_W = 23;

  // Quotient of a year-sized value by 100 (at most 164)
  localparam int unsigned QUO_W = 8;

  // Reciprocal of 100, exact for operands below 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [SHARED_W-1:0] SHARED_MAX = {SHARED_W{1'b1}};

  // Calendar constants
  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
  localparam logic [3:0] MONTH_JAN     = 4'd1;
  localparam logic [3:0] MONTH_DEC     = 4'd12;
  localparam logic [3:0] IDX_FEB       = 4'd1;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef logic [DNUM_W-1:0] dnum_t;

  // Days in the months that precede the month with the given zero-based index
  function automatic logic [8:0] days_before_month(input logic [3:0] idx);
    logic [8:0] res;
    case (idx)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd59;
      4'd3:    res = 9'd90;
      4'd4:    res = 9'd120;
      4'd5:    res = 9'd151;
      4'd6:    res = 9'd181;
      4'd7:    res = 9'd212;
      4'd8:    res = 9'd243;
      4'd9:    res = 9'd273;
      4'd10:   res = 9'd304;
      default: res = 9'd334;
    endcase
    return res;
  endfunction

  // Floor division by 100 through a reciprocal multiply
  function automatic logic [QUO_W-1:0] div100(input logic [YEAR_W:0] v);
    logic [YEAR_W+13:0] prod;
    prod = {13'd0, v} * {{(YEAR_W+1){1'b0}}, RECIP_100};
    return prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
  endfunction

endpackage

// ===== rtl/dpod_daynum.sv =====
// Three-stage pipeline that turns one Gregorian date into a linear day number.
module dpod_daynum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  dpod_pkg::date_t date_i,
  output logic           vld_o,
  output dpod_pkg::dnum_t dnum_o
);
  import dpod_pkg::*;

  // Stage 1 registers
  logic               vld1_r;
  logic [YEAR_W-1:0]  year1_r;
  logic [3:0]         midx1_r;
  logic [DAY_W-1:0]   day1_r;
  logic [QUO_W-1:0]   qceil1_r;
  logic [QUO_W-1:0]   qfloor1_r;
  logic [3:0]         midx1_nxt;

  // Stage 2 registers
  logic               vld2_r;
  dnum_t              base2_r;
  logic [9:0]         doy2_r;
  dnum_t              base2_nxt;
  logic [9:0]         doy2_nxt;
  logic               leap2;
  logic               cent2;

  // Stage 3 registers
  logic               vld3_r;
  dnum_t              dnum3_r;

  // Clamp the month into January..December and make it zero based
  always_comb begin
    if (date_i.month < MONTH_JAN) begin
      midx1_nxt = 4'd0;
    end else if (date_i.month > MONTH_DEC) begin
      midx1_nxt = MONTH_DEC - 4'd1;
    end else begin
      midx1_nxt = date_i.month - 4'd1;
    end
  end

  // Stage 1: take ceil and floor of year / 100
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
    end
    year1_r   <= date_i.year;
    midx1_r   <= midx1_nxt;
    day1_r    <= date_i.day;
    qceil1_r  <= div100({1'b0, date_i.year} + (YEAR_W+1)'(99));
    qfloor1_r <= div100({1'b0, date_i.year});
  end

  // Century year when ceil and floor agree; leap by the 4/100/400 rule
  always_comb begin
    cent2 = (qceil1_r == qfloor1_r);
    leap2 = (year1_r[1:0] == 2'b00 && !cent2) || (cent2 && qfloor1_r[1:0] == 2'b00);
    // leap days in years 0 .. y-1: ceil(y/4) - ceil(y/100) + ceil(y/400)
    base2_nxt = DNUM_W'(year1_r) * DNUM_W'(DAYS_PER_YEAR)
              + DNUM_W'(({1'b0, year1_r} + (YEAR_W+1)'(3)) >> 2)
              - DNUM_W'(qceil1_r)
              + DNUM_W'(({1'b0, qceil1_r} + 9'd3) >> 2);
    doy2_nxt  = 10'(days_before_month(midx1_r))
              + 10'(leap2 && midx1_r > IDX_FEB)
              + 10'(day1_r);
  end

  // Stage 2: year base and day of year
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    base2_r <= base2_nxt;
    doy2_r  <= doy2_nxt;
  end

  // Stage 3: add up the day number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    dnum3_r <= base2_r + DNUM_W'(doy2_r);
  end

  assign vld_o  = vld3_r;
  assign dnum_o = dnum3_r;

endmodule

// ===== rtl/dpod_overlap.sv =====
// Two-stage pipeline that intersects two day-number intervals and counts shared days.
module dpod_overlap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  dpod_pkg::dnum_t                   s1_i,
  input  dpod_pkg::dnum_t                   e1_i,
  input  dpod_pkg::dnum_t                   s2_i,
  input  dpod_pkg::dnum_t                   e2_i,
  output logic                              vld_o,
  output logic [dpod_pkg::SHARED_W-1:0]     shared_o
);
  import dpod_pkg::*;

  logic                vld1_r;
  dnum_t               lo1_r;
  dnum_t               hi1_r;
  logic                ok1_r;

  logic                vld2_r;
  logic [SHARED_W-1:0] shared2_r;
  logic [SHARED_W-1:0] shared2_nxt;
  logic [DNUM_W:0]     span2;

  // Stage 1: later start, earlier end, both periods non-empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
    end
    lo1_r <= (s1_i > s2_i) ? s1_i : s2_i;
    hi1_r <= (e1_i < e2_i) ? e1_i : e2_i;
    ok1_r <= (e1_i >= s1_i) && (e2_i >= s2_i);
  end

  // Count both ends and saturate at the field's maximum
  always_comb begin
    span2       = {1'b0, hi1_r} - {1'b0, lo1_r} + (DNUM_W+1)'(1);
    shared2_nxt = '0;
    if (ok1_r && hi1_r >= lo1_r) begin
      if (span2 > (DNUM_W+1)'(SHARED_MAX)) begin
        shared2_nxt = SHARED_MAX;
      end else begin
        shared2_nxt = span2[SHARED_W-1:0];
      end
    end
  end

  // Stage 2: result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    shared2_r <= shared2_nxt;
  end

  assign vld_o    = vld2_r;
  assign shared_o = shared2_r;

endmodule

// ===== rtl/date_period_overlap_days_top.sv =====
// Top level of the date period overlap counter: four date lanes and the overlap stage.
//
// Takes two Gregorian date periods per transfer and returns the number of days they
// share, counting both ends (zero when they do not meet or a period is empty). A new
// transfer can start in every cycle; busy stays low. Each result appears on the out_
// ports for exactly one cycle, marked by out_valid: the four dates are first converted
// to day numbers in parallel lanes, then the intervals are intersected and counted.
// The receiver cannot stall, so results must be taken as they come. Results leave in
// the order the transfers were started.
module date_period_overlap_days_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [13:0] in_first_start_year,
  input  logic [3:0]  in_first_start_month,
  input  logic [4:0]  in_first_start_day,
  input  logic [13:0] in_first_end_year,
  input  logic [3:0]  in_first_end_month,
  input  logic [4:0]  in_first_end_day,
  input  logic [13:0] in_second_start_year,
  input  logic [3:0]  in_second_start_month,
  input  logic [4:0]  in_second_start_day,
  input  logic [13:0] in_second_end_year,
  input  logic [3:0]  in_second_end_month,
  input  logic [4:0]  in_second_end_day,
  output logic        out_valid,
  output logic [21:0] out_shared_days
);
  import dpod_pkg::*;

  logic  accept;
  date_t d_s1;
  date_t d_e1;
  date_t d_s2;
  date_t d_e2;
  logic  dn_vld;
  logic  dn_vld_s1;
  logic  dn_vld_e1;
  logic  dn_vld_s2;
  logic  dn_vld_e2;
  dnum_t dn_s1;
  dnum_t dn_e1;
  dnum_t dn_s2;
  dnum_t dn_e2;

  // Pipeline never holds off a transfer
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Bundle the date fields
  assign d_s1 = '{year: in_first_start_year,  month: in_first_start_month,
                  day: in_first_start_day};
  assign d_e1 = '{year: in_first_end_year,    month: in_first_end_month,
                  day: in_first_end_day};
  assign d_s2 = '{year: in_second_start_year, month: in_second_start_month,
                  day: in_second_start_day};
  assign d_e2 = '{year: in_second_end_year,   month: in_second_end_month,
                  day: in_second_end_day};

  // Date lanes; all four advance in lockstep
  dpod_daynum u_dn_s1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (accept),
    .date_i (d_s1),
    .vld_o  (dn_vld_s1),
    .dnum_o (dn_s1)
  );

  dpod_daynum u_dn_e1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (accept),
    .date_i (d_e1),
    .vld_o  (dn_vld_e1),
    .dnum_o (dn_e1)
  );

  dpod_daynum u_dn_s2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (accept),
    .date_i (d_s2),
    .vld_o  (dn_vld_s2),
    .dnum_o (dn_s2)
  );

  dpod_daynum u_dn_e2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (accept),
    .date_i (d_e2),
    .vld_o  (dn_vld_e2),
    .dnum_o (dn_e2)
  );

  // Combine the lane valid bits
  assign dn_vld = dn_vld_s1 & dn_vld_e1 & dn_vld_s2 & dn_vld_e2;

  // Intersect and count
  dpod_overlap u_overlap (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (dn_vld),
    .s1_i     (dn_s1),
    .e1_i     (dn_e1),
    .s2_i     (dn_s2),
    .e2_i     (dn_e2),
    .vld_o    (out_valid),
    .shared_o (out_shared_days)
  );

`ifndef SYNTHESIS
  // Every transfer yields a result
  a_start_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("transfer produced no result");

  // No result without an earlier transfer
  a_result_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result without transfer");

  // Reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  // Lanes stay aligned
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (dn_vld_s1 == dn_vld_e1) && (dn_vld_s1 == dn_vld_s2) && (dn_vld_s1 == dn_vld_e2))
    else $error("date lanes out of step");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the date period overlap counter: directed table, then random periods.
module tb_top;
  import dpod_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned YEAR_MAX     = (1 << YEAR_W) - 1;

  // Days in the months before each month of a common year
  localparam int unsigned CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    date_t first_start;
    date_t first_end;
    date_t second_start;
    date_t second_end;
  } query_t;

  // One directed row; the count is typed in only where it is obvious
  typedef struct packed {
    query_t              query;
    logic                typed;
    logic [SHARED_W-1:0] shared;
  } vector_t;

  localparam vector_t DIRECTED [22] = '{
    // single shared day
    '{'{'{2000, 1, 1}, '{2000, 1, 1}, '{2000, 1, 1}, '{2000, 1, 1}}, 1'b1, 22'd1},
    // full valid span in both periods
    '{'{'{1, 1, 1}, '{9999, 12, 31}, '{1, 1, 1}, '{9999, 12, 31}}, 1'b1, 22'd3652059},
    // widest possible span saturates
    '{'{'{0, 0, 0}, '{16383, 15, 31}, '{0, 0, 0}, '{16383, 15, 31}}, 1'b1, SHARED_MAX},
    // all-ones date against itself
    '{'{'{16383, 15, 31}, '{16383, 15, 31}, '{16383, 15, 31}, '{16383, 15, 31}}, 1'b1, 22'd1},
    // adjacent years do not meet
    '{'{'{2000, 1, 1}, '{2000, 12, 31}, '{2001, 1, 1}, '{2001, 12, 31}}, 1'b1, 22'd0},
    // first period empty
    '{'{'{2000, 12, 31}, '{2000, 1, 1}, '{1999, 1, 1}, '{2001, 1, 1}}, 1'b1, 22'd0},
    // second period empty
    '{'{'{1999, 1, 1}, '{2001, 1, 1}, '{2000, 6, 2}, '{2000, 6, 1}}, 1'b1, 22'd0},
    // both periods empty
    '{'{'{2010, 5, 5}, '{2009, 5, 5}, '{2010, 5, 5}, '{2009, 5, 5}}, 1'b1, 22'd0},
    // second period entirely before the first
    '{'{'{2005, 3, 1}, '{2006, 3, 1}, '{2003, 1, 1}, '{2004, 12, 31}}, 1'b1, 22'd0},
    // periods touch on one day
    '{'{'{2000, 1, 1}, '{2000, 6, 15}, '{2000, 6, 15}, '{2000, 12, 31}}, 1'b1, 22'd1},
    // whole January contained in a long period
    '{'{'{1990, 5, 5}, '{2010, 5, 5}, '{2000, 1, 1}, '{2000, 1, 31}}, 1'b1, 22'd31},
    // leap February: divisible by 400, by 100 only, by 4 only
    '{'{'{2000, 2, 28}, '{2000, 3, 1}, '{2000, 2, 1}, '{2000, 3, 31}}, 1'b0, 22'd0},
    '{'{'{1900, 2, 28}, '{1900, 3, 1}, '{1900, 2, 1}, '{1900, 3, 31}}, 1'b0, 22'd0},
    '{'{'{2004, 1, 15}, '{2004, 4, 1}, '{2003, 12, 1}, '{2004, 3, 2}}, 1'b0, 22'd0},
    // month zero reads as January, months above twelve as December
    '{'{'{2020, 0, 15}, '{2020, 1, 15}, '{2020, 1, 1}, '{2020, 1, 31}}, 1'b0, 22'd0},
    '{'{'{2020, 13, 1}, '{2020, 15, 31}, '{2020, 12, 10}, '{2020, 14, 20}}, 1'b0, 22'd0},
    // day zero and day past the month end run over month borders
    '{'{'{2021, 3, 0}, '{2021, 3, 0}, '{2021, 2, 28}, '{2021, 2, 28}}, 1'b0, 22'd0},
    '{'{'{2021, 2, 31}, '{2021, 3, 3}, '{2021, 3, 1}, '{2021, 3, 5}}, 1'b0, 22'd0},
    // year zero is leap and precedes year one
    '{'{'{0, 1, 1}, '{0, 12, 31}, '{0, 2, 29}, '{1, 1, 1}}, 1'b0, 22'd0},
    '{'{'{0, 12, 31}, '{1, 1, 1}, '{1, 1, 1}, '{1, 1, 1}}, 1'b0, 22'd0},
    // partial overlap across a year boundary
    '{'{'{1999, 12, 1}, '{2000, 1, 10}, '{2000, 1, 1}, '{2000, 3, 31}}, 1'b0, 22'd0},
    // large years, overlap well below the saturation point
    '{'{'{11000, 1, 1}, '{16383, 12, 31}, '{1, 1, 1}, '{16000, 1, 1}}, 1'b0, 22'd0}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  query_t              drv_query;
  logic                drv_typed;
  logic [SHARED_W-1:0] drv_shared;
  logic                out_valid;
  logic [SHARED_W-1:0] out_shared_days;

  logic [SHARED_W-1:0] shared_q[$];
  logic [SHARED_W-1:0] want_shared;
  int unsigned         fail_count    = 0;
  int unsigned         sent_count    = 0;
  int unsigned         result_count  = 0;
  int unsigned         overlap_count = 0;
  int unsigned         sat_count     = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  date_period_overlap_days_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_first_start_year   (drv_query.first_start.year),
    .in_first_start_month  (drv_query.first_start.month),
    .in_first_start_day    (drv_query.first_start.day),
    .in_first_end_year     (drv_query.first_end.year),
    .in_first_end_month    (drv_query.first_end.month),
    .in_first_end_day      (drv_query.first_end.day),
    .in_second_start_year  (drv_query.second_start.year),
    .in_second_start_month (drv_query.second_start.month),
    .in_second_start_day   (drv_query.second_start.day),
    .in_second_end_year    (drv_query.second_end.year),
    .in_second_end_month   (drv_query.second_end.month),
    .in_second_end_day     (drv_query.second_end.day),
    .out_valid             (out_valid),
    .out_shared_days       (out_shared_days)
  );

  // Linear day number of a date, with out-of-range months clamped
  function automatic int unsigned day_index(date_t d);
    int unsigned y;
    int unsigned m;
    int unsigned n;
    y = d.year;
    m = d.month;
    if (m < MONTH_JAN) m = MONTH_JAN;
    if (m > MONTH_DEC) m = MONTH_DEC;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    n += CUM_DAYS[m - 1];
    if (m > 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0)) n += 1;
    return n + d.day;
  endfunction

  // Days shared by both periods, both ends counted, saturated
  function automatic logic [SHARED_W-1:0] overlap_days(query_t q);
    int unsigned s1, e1, s2, e2, lo, hi;
    s1 = day_index(q.first_start);
    e1 = day_index(q.first_end);
    s2 = day_index(q.second_start);
    e2 = day_index(q.second_end);
    lo = (s1 > s2) ? s1 : s2;
    hi = (e1 < e2) ? e1 : e2;
    if (e1 < s1 || e2 < s2 || hi < lo) return '0;
    if (hi - lo + 1 > SHARED_MAX) return SHARED_MAX;
    return SHARED_W'(hi - lo + 1);
  endfunction

  // Random date near a center year; mostly valid months and days
  function automatic date_t rand_date(int unsigned center, int unsigned span);
    date_t       d;
    int unsigned lo_y;
    int unsigned hi_y;
    lo_y = (center > span) ? center - span : 0;
    hi_y = (center + span > YEAR_MAX) ? YEAR_MAX : center + span;
    d.year = YEAR_W'($urandom_range(hi_y, lo_y));
    if ($urandom_range(9, 0) == 0) d.month = MONTH_W'($urandom_range(15, 0));
    else d.month = MONTH_W'($urandom_range(12, 1));
    if ($urandom_range(3, 0) == 0) d.day = DAY_W'($urandom_range(31, 0));
    else d.day = DAY_W'($urandom_range(28, 1));
    return d;
  endfunction

  // Random pair of periods; most periods are put in order so they overlap often
  function automatic query_t rand_query();
    query_t      q;
    date_t       t;
    int unsigned center;
    int unsigned span;
    if ($urandom_range(3, 0) == 0) center = $urandom_range(YEAR_MAX, 0);
    else center = $urandom_range(9999, 1);
    case ($urandom_range(4, 0))
      0:       span = 0;
      1:       span = 1;
      2:       span = 20;
      3:       span = 400;
      default: span = YEAR_MAX;
    endcase
    q.first_start  = rand_date(center, span);
    q.first_end    = rand_date(center, span);
    q.second_start = rand_date(center, span);
    q.second_end   = rand_date(center, span);
    if ($urandom_range(9, 0) != 0 && day_index(q.first_end) < day_index(q.first_start)) begin
      t = q.first_start;
      q.first_start = q.first_end;
      q.first_end = t;
    end
    if ($urandom_range(9, 0) != 0 && day_index(q.second_end) < day_index(q.second_start)) begin
      t = q.second_start;
      q.second_start = q.second_end;
      q.second_end = t;
    end
    return q;
  endfunction

  // Present one query and hold it until the transfer
  task automatic send_query(query_t q, logic typed, logic [SHARED_W-1:0] shared);
    drv_query  <= q;
    drv_typed  <= typed;
    drv_shared <= shared;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // Drop start for a number of cycles (at least one)
  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and wait until every expected count has arrived
  task automatic drain_results();
    pause(1);
    while (shared_q.size() != 0) @(posedge clk);
  endtask

  // Record each transfer's expected count and check each result
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        shared_q.push_back(drv_typed ? drv_shared : overlap_days(drv_query));
      if ($isunknown(out_valid)) begin
        $error("out_valid is unknown");
        fail_count++;
      end else if (out_valid) begin
        if (shared_q.size() == 0) begin
          $error("unexpected result: shared_days=%0d", out_shared_days);
          fail_count++;
        end else begin
          want_shared = shared_q.pop_front();
          result_count++;
          if (want_shared != 0) overlap_count++;
          if (want_shared == SHARED_MAX) sat_count++;
          if (out_shared_days !== want_shared) begin
            $error("shared_days mismatch: expected %0d, actual %0d", want_shared, out_shared_days);
            fail_count++;
          end
        end
      end
    end
  end

  // End the run if it hangs
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned burst;
    int unsigned k;
    int unsigned random_sent;
    bit          mid_drained;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    drv_query  <= '0;
    drv_typed  <= 1'b0;
    drv_shared <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table with short gaps now and then
    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_query(DIRECTED[i].query, DIRECTED[i].typed, DIRECTED[i].shared);
      if (i % 5 == 4) pause($urandom_range(3, 1));
    end
    drain_results();

    // Random bursts with random gaps; sometimes no gap, so bursts run together
    random_sent = 0;
    mid_drained = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      burst = $urandom_range(24, 1);
      for (k = 0; k < burst && random_sent < RANDOM_ITEMS; k++) begin
        send_query(rand_query(), 1'b0, '0);
        random_sent++;
      end
      if (!mid_drained && random_sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        mid_drained = 1'b1;
      end else if ($urandom_range(3, 0) != 0) begin
        pause($urandom_range(7, 1));
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shared_q.size() != 0) begin
      $error("%0d expected results never arrived", shared_q.size());
      fail_count++;
    end

    $display("Sent %0d period pairs (%0d from the directed table), checked %0d counts.",
             sent_count, $size(DIRECTED), result_count);
    $display("%0d pairs shared at least one day, %0d counts saturated.",
             overlap_count, sat_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
